// ===== rtl/mrf_pkg.sv =====
// shared types, constants and crc function of the modbus rtu request framer
package mrf_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic [7:0]  FuncReadHolding   = 8'h03;
  localparam logic [7:0]  FuncWriteMultiple = 8'h10;
  localparam logic [15:0] CrcInit           = 16'hFFFF;
  localparam logic [15:0] CrcPoly           = 16'hA001;
  localparam logic [3:0]  ReadBodyLen       = 4'd6;
  localparam logic [3:0]  WriteBodyLen      = 4'd9;

  typedef struct packed {
    logic [15:0] data_word;
    logic [7:0]  byte_count;
    logic [15:0] register_count;
    logic [15:0] start_address;
    logic [7:0]  device_id;
  } req_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/modbus_rtu_request_framer_core.sv =====
// modbus rtu request framer: request in, frame bytes with crc-16 out
// first frame byte passes the queued-request, active-request and output registers after the request transfer
// frames: 8 bytes per read request, 11 per write request, one byte per cycle while m_axis_tready allows;
//   a queued request starts on the cycle after the last byte
// reset: asynchronous active low, clears all valid flags and the byte index
module modbus_rtu_request_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // device_id, start_address, register_count, byte_count, data_word
  input  logic [0:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // frame_byte
  output logic        m_axis_tlast
);

  // queued request
  logic               pend_valid_q, pend_valid_d;
  mrf_pkg::req_t      pend_req_q;
  mrf_pkg::op_e       pend_op_q;

  // request being sent
  logic               act_valid_q, act_valid_d;
  mrf_pkg::req_t      act_req_q;
  mrf_pkg::op_e       act_op_q;
  logic [3:0]         idx_q, idx_d;
  logic [15:0]        crc_q, crc_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q;
  logic               out_last_q;

  logic               s_xfer;
  logic               out_load;
  logic               act_done;
  logic               act_take;
  logic [3:0]         body_len;
  logic [7:0]         cur_byte;
  logic               cur_last;

  assign s_axis_tready = !pend_valid_q;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign body_len = (act_op_q == mrf_pkg::OP_WRITE) ? mrf_pkg::WriteBodyLen
                                                    : mrf_pkg::ReadBodyLen;

  always_comb begin
    case (idx_q)
      4'd0:    cur_byte = act_req_q.device_id;
      4'd1:    cur_byte = (act_op_q == mrf_pkg::OP_WRITE) ? mrf_pkg::FuncWriteMultiple
                                                          : mrf_pkg::FuncReadHolding;
      4'd2:    cur_byte = act_req_q.start_address[15:8];
      4'd3:    cur_byte = act_req_q.start_address[7:0];
      4'd4:    cur_byte = act_req_q.register_count[15:8];
      4'd5:    cur_byte = act_req_q.register_count[7:0];
      default: cur_byte = 8'h00;
    endcase
    if (act_op_q == mrf_pkg::OP_WRITE) begin
      case (idx_q)
        4'd6:    cur_byte = act_req_q.byte_count;
        4'd7:    cur_byte = act_req_q.data_word[15:8];
        4'd8:    cur_byte = act_req_q.data_word[7:0];
        default: ;
      endcase
    end
    if (idx_q == body_len) begin
      cur_byte = crc_q[7:0];
    end else if (idx_q == body_len + 4'd1) begin
      cur_byte = crc_q[15:8];
    end
  end

  assign cur_last = (idx_q == body_len + 4'd1);
  assign out_load = act_valid_q && (!out_valid_q || m_axis_tready);
  assign act_done = out_load && cur_last;
  assign act_take = pend_valid_q && (!act_valid_q || act_done);

  always_comb begin
    pend_valid_d = pend_valid_q;
    act_valid_d  = act_valid_q;
    idx_d        = idx_q;
    crc_d        = crc_q;
    out_valid_d  = out_valid_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 4'd1;
      if (idx_q < body_len) begin
        crc_d = mrf_pkg::crc_update(crc_q, cur_byte);
      end
      if (cur_last) begin
        act_valid_d = 1'b0;
      end
    end
    if (act_take) begin
      act_valid_d  = 1'b1;
      idx_d        = 4'd0;
      crc_d        = mrf_pkg::CrcInit;
      pend_valid_d = 1'b0;
    end
    if (s_xfer) begin
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      act_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= 4'd0;
      crc_q        <= mrf_pkg::CrcInit;
    end else begin
      pend_valid_q <= pend_valid_d;
      act_valid_q  <= act_valid_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      crc_q        <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      pend_req_q <= mrf_pkg::req_t'(s_axis_tdata);
      pend_op_q  <= mrf_pkg::op_e'(s_axis_tuser[0]);
    end
    if (act_take) begin
      act_req_q <= pend_req_q;
      act_op_q  <= pend_op_q;
    end
    if (out_load) begin
      out_byte_q <= cur_byte;
      out_last_q <= cur_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench of the modbus rtu request framer: directed and random requests
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 30;

  typedef struct {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  frame_beat_t expected_beats[$];
  int          mismatches;
  int          cycle_count;
  bit          idle_en;
  int          hold_requests;
  int          holds_served;
  int          hold_left;

  modbus_rtu_request_framer_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] modbus_crc16(input logic [7:0] body[], input int len);
    logic [15:0] crc;
    crc = mrf_pkg::CrcInit;
    for (int k = 0; k < len; k++) begin
      crc[7:0] = crc[7:0] ^ body[k];
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ mrf_pkg::CrcPoly) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  // expected frame bytes of one request, in transmit order
  function automatic void predict_frame(input mrf_pkg::op_e op, input mrf_pkg::req_t req);
    logic [7:0]  body[];
    logic [15:0] crc;
    int          len;
    frame_beat_t beat;
    len = (op == mrf_pkg::OP_WRITE) ? 9 : 6;
    body = new[len];
    body[0] = req.device_id;
    body[1] = (op == mrf_pkg::OP_WRITE) ? mrf_pkg::FuncWriteMultiple
                                        : mrf_pkg::FuncReadHolding;
    body[2] = req.start_address[15:8];
    body[3] = req.start_address[7:0];
    body[4] = req.register_count[15:8];
    body[5] = req.register_count[7:0];
    if (op == mrf_pkg::OP_WRITE) begin
      body[6] = req.byte_count;
      body[7] = req.data_word[15:8];
      body[8] = req.data_word[7:0];
    end
    crc = modbus_crc16(body, len);
    for (int k = 0; k < len; k++) begin
      beat.frame_byte = body[k];
      beat.last_byte = 1'b0;
      expected_beats.push_back(beat);
    end
    beat.frame_byte = crc[7:0];
    beat.last_byte = 1'b0;
    expected_beats.push_back(beat);
    beat.frame_byte = crc[15:8];
    beat.last_byte = 1'b1;
    expected_beats.push_back(beat);
  endfunction

  // frame byte checker
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected frame byte %02h last %0b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (m_tdata !== want.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", want.frame_byte, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", want.last_byte, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HoldCycles - 1;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(99) < 30) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input mrf_pkg::op_e op, input mrf_pkg::req_t req);
    if (idle_en && $urandom_range(99) < 30) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      while ($urandom_range(99) < 30) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_frame(op, req);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mrf_pkg::req_t random_request();
    mrf_pkg::req_t req;
    req.device_id      = 8'(pick_word());
    req.start_address  = pick_word();
    req.register_count = pick_word();
    req.byte_count     = 8'(pick_word());
    req.data_word      = pick_word();
    return req;
  endfunction

  function automatic mrf_pkg::req_t make_req(input logic [7:0] dev, input logic [15:0] addr,
                                             input logic [15:0] cnt, input logic [7:0] nbytes,
                                             input logic [15:0] data);
    mrf_pkg::req_t req;
    req.device_id      = dev;
    req.start_address  = addr;
    req.register_count = cnt;
    req.byte_count     = nbytes;
    req.data_word      = data;
    return req;
  endfunction

  task automatic test_field_extremes();
    idle_en = 1'b0;
    send_request(mrf_pkg::OP_READ,  make_req(8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_request(mrf_pkg::OP_READ,  make_req(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_request(mrf_pkg::OP_WRITE, make_req(8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_request(mrf_pkg::OP_WRITE, make_req(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_request(mrf_pkg::OP_READ,  make_req(8'h55, 16'hAAAA, 16'h5555, 8'hAA, 16'h5555));
    send_request(mrf_pkg::OP_WRITE, make_req(8'hAA, 16'h5555, 16'hAAAA, 8'h55, 16'hAAAA));
    // typical read, the same read with junk in the unused fields, then a typical write
    send_request(mrf_pkg::OP_READ,  make_req(8'h01, 16'h0000, 16'h000A, 8'h00, 16'h0000));
    send_request(mrf_pkg::OP_READ,  make_req(8'h01, 16'h0000, 16'h000A, 8'hC3, 16'hBEEF));
    send_request(mrf_pkg::OP_WRITE, make_req(8'h11, 16'h0001, 16'h0001, 8'h02, 16'h1234));
    // inconsistent count fields go out unchanged
    send_request(mrf_pkg::OP_WRITE, make_req(8'h11, 16'h0001, 16'h0007, 8'h09, 16'h1234));
    send_request(mrf_pkg::OP_WRITE, make_req(8'hF7, 16'h8000, 16'h0000, 8'h00, 16'h8001));
    send_request(mrf_pkg::OP_READ,  make_req(8'h80, 16'h0001, 16'h8000, 8'h01, 16'h0001));
  endtask

  task automatic test_random_requests(input int count);
    for (int i = 0; i < count; i++) begin
      // one long stretch runs with no idling on either side
      idle_en = !(i >= count / 3 && i < count / 3 + 100);
      send_request(mrf_pkg::op_e'($urandom_range(1)), random_request());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_requests++;
    for (int i = 0; i < 30; i++) begin
      send_request(mrf_pkg::op_e'($urandom_range(1)), random_request());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 30; i++) begin
      send_request(mrf_pkg::op_e'($urandom_range(1)), random_request());
      if (i % 10 == 9) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_beats.size() == 0);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    mismatches  = 0;
    cycle_count = 0;
    idle_en     = 1'b1;
    hold_requests = 0;
    holds_served  = 0;
    hold_left     = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_random_requests(380);
    test_backpressure();
    test_drain_pause();

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mrf_pkg.sv
rtl/modbus_rtu_request_framer_core.sv
bench/tb_top.sv
